// ----- rtl/core/rpst_pkg.sv -----
// Package for the RGB pixel serial transmitter.
// Holds channel payload types, operation codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package rpst_pkg;

	localparam int unsigned FRAME_BITS_DEF = 24;
	localparam int unsigned TIMING_W       = 8;
	localparam int unsigned COLOUR_W       = 24;
	localparam int unsigned REG_IDX_W      = 2;

	typedef enum logic {
		OP_SEND = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HIGH_ONE  = 2'd0,
		REG_HIGH_ZERO = 2'd1,
		REG_LOW       = 2'd2
	} reg_idx_t;

	localparam logic [TIMING_W-1:0] HIGH_ONE_RST  = 8'd15;
	localparam logic [TIMING_W-1:0] HIGH_ZERO_RST = 8'd4;
	localparam logic [TIMING_W-1:0] LOW_RST       = 8'd15;

	typedef struct packed {
		op_t        op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic accepted;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	// timing register of zero behaves as one
	function automatic logic [TIMING_W-1:0] at_least_one(input logic [TIMING_W-1:0] v);
		return (v == '0) ? TIMING_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rpst_if.sv -----
// Valid/ready channel interfaces for the transmitter's input and result items.
// Depends on rpst_pkg for the payload types.
`default_nettype none

interface rpst_in_if;
	import rpst_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rpst_out_if;
	import rpst_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rgb_pixel_serial_transmitter_core.sv -----
// RGB pixel serial transmitter: single-wire LED bit timing, one result per item.
// Each result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one item per cycle while the skid register is empty; it keeps input open while a result waits.
// Input ready drops only while both output register and skid register are full.
// Reset (arst_n, async low): idle, line low, timing registers to 15 / 4 / 15.
// Depends on rpst_pkg and rpst_if.
`default_nettype none

module rgb_pixel_serial_transmitter_core #(
	parameter int unsigned BITS_PER_FRAME = rpst_pkg::FRAME_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	rpst_in_if.sink                                   in_ch,
	rpst_out_if.source                                out_ch,
	input  wire logic                                 wr_en,
	input  wire logic [rpst_pkg::REG_IDX_W-1:0]       wr_index,
	input  wire logic [rpst_pkg::TIMING_W-1:0]        wr_data
);
	import rpst_pkg::*;

	localparam int unsigned CNT_W = $clog2(BITS_PER_FRAME);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_FRAME - 1);

	// timing registers
	logic [TIMING_W-1:0] high_one_q, high_zero_q, low_q;

	// transmitter state
	logic [COLOUR_W-1:0] shift_q, shift_d;
	logic [CNT_W-1:0]    bcnt_q, bcnt_d;
	logic                hi_q, hi_d;
	logic [TIMING_W-1:0] timer_q, timer_d;
	logic                busy_q, busy_d;
	logic                acc_d, done_d;

	out_item_t res;
	out_item_t out_q, skid_q;
	logic      out_v_q, skid_v_q;
	logic      in_xfer;

	assign in_ch.ready = !skid_v_q;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_one_q  <= HIGH_ONE_RST;
			high_zero_q <= HIGH_ZERO_RST;
			low_q       <= LOW_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HIGH_ONE:  high_one_q  <= wr_data;
				REG_HIGH_ZERO: high_zero_q <= wr_data;
				REG_LOW:       low_q       <= wr_data;
				default:       ;
			endcase
		end
	end

	always_comb begin
		shift_d = shift_q;
		bcnt_d  = bcnt_q;
		hi_d    = hi_q;
		timer_d = timer_q;
		busy_d  = busy_q;
		acc_d   = 1'b0;
		done_d  = 1'b0;
		if (in_ch.data.op == OP_SEND) begin
			if (!busy_q) begin
				shift_d = {in_ch.data.green, in_ch.data.red, in_ch.data.blue};
				bcnt_d  = '0;
				busy_d  = 1'b1;
				hi_d    = 1'b1;
				timer_d = at_least_one(in_ch.data.green[7] ? high_one_q : high_zero_q);
				acc_d   = 1'b1;
			end
		end else if (busy_q) begin
			if (timer_q > TIMING_W'(1)) begin
				timer_d = timer_q - TIMING_W'(1);
			end else if (hi_q) begin
				hi_d    = 1'b0;
				timer_d = at_least_one(low_q);
			end else if (bcnt_q == LAST_BIT) begin
				busy_d  = 1'b0;
				timer_d = '0;
				shift_d = {shift_q[COLOUR_W-2:0], 1'b0};
				bcnt_d  = '0;
				done_d  = 1'b1;
			end else begin
				bcnt_d  = bcnt_q + CNT_W'(1);
				shift_d = {shift_q[COLOUR_W-2:0], 1'b0};
				hi_d    = 1'b1;
				timer_d = at_least_one(shift_q[COLOUR_W-2] ? high_one_q : high_zero_q);
			end
		end
		res.line_level = busy_d && hi_d;
		res.accepted   = acc_d;
		res.busy_res   = busy_d;
		res.frame_done = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			bcnt_q  <= '0;
			hi_q    <= 1'b0;
			timer_q <= '0;
			busy_q  <= 1'b0;
		end else if (in_xfer) begin
			shift_q <= shift_d;
			bcnt_q  <= bcnt_d;
			hi_q    <= hi_d;
			timer_q <= timer_d;
			busy_q  <= busy_d;
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !out_ch.ready) begin
			if (in_xfer) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !out_ch.ready) begin
			if (in_xfer) begin
				skid_q <= res;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (in_xfer) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_line_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.line_level |-> out_ch.data.busy_res)
		else $error("line driven high while idle");

	a_accept_starts_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.accepted |-> out_ch.data.line_level)
		else $error("accepted send did not drive the line high");

	a_done_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.frame_done |->
			!out_ch.data.busy_res && !out_ch.data.accepted)
		else $error("frame end reported while still busy");

	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> timer_q != '0)
		else $error("phase timer empty during a frame");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for rgb_pixel_serial_transmitter_core: drives send and tick items and
// predicts each line level, take flag, busy flag and end of frame, then checks them.
// Depends on rpst_pkg and the rpst_in_if / rpst_out_if channel interfaces.
`timescale 1ns / 100ps

module tb_top;
	import rpst_pkg::*;

	localparam int FRAME_BITS  = FRAME_BITS_DEF;
	localparam int DRAIN_SLACK = 8;
	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [TIMING_W-1:0]  wr_data;

	rpst_in_if  in_ch ();
	rpst_out_if out_ch ();

	rgb_pixel_serial_transmitter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// predicted transmitter state and timing registers
	logic [COLOUR_W-1:0] tx_shift;
	logic [4:0]          tx_bit;
	logic                tx_high;
	logic [TIMING_W-1:0] tx_timer;
	logic                tx_busy;
	logic [TIMING_W-1:0] cfg_one, cfg_zero, cfg_low;

	out_item_t line_states[$];
	int        errors = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= (arst_n === 1'b1) &&
			((stall_pct == 0) || ($urandom_range(99) >= stall_pct));
	end

	function automatic logic [TIMING_W-1:0] floor_one(input logic [TIMING_W-1:0] v);
		return (v == '0) ? TIMING_W'(1) : v;
	endfunction

	task automatic load_high_phase();
		tx_high  = 1'b1;
		tx_timer = tx_shift[COLOUR_W-1] ? floor_one(cfg_one) : floor_one(cfg_zero);
	endtask

	task automatic predict_line(input in_item_t it, output out_item_t r);
		logic taken;
		logic done;
		taken = 1'b0;
		done  = 1'b0;
		if (it.op == OP_SEND) begin
			if (!tx_busy) begin
				tx_shift = {it.green, it.red, it.blue};
				tx_bit   = '0;
				tx_busy  = 1'b1;
				load_high_phase();
				taken = 1'b1;
			end
		end else if (tx_busy) begin
			if (tx_timer > 1) begin
				tx_timer = tx_timer - 1'b1;
			end else if (tx_high) begin
				tx_high  = 1'b0;
				tx_timer = floor_one(cfg_low);
			end else if (int'(tx_bit) + 1 >= FRAME_BITS) begin
				tx_busy  = 1'b0;
				tx_timer = '0;
				tx_shift = tx_shift << 1;
				tx_bit   = '0;
				done     = 1'b1;
			end else begin
				tx_bit   = tx_bit + 1'b1;
				tx_shift = tx_shift << 1;
				load_high_phase();
			end
		end
		r.line_level = tx_busy && tx_high;
		r.accepted   = taken;
		r.busy_res   = tx_busy;
		r.frame_done = done;
	endtask

	task automatic report_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (line_states.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $time, out_ch.data);
				errors++;
			end else begin
				want = line_states.pop_front();
				report_field("line_level", want.line_level, out_ch.data.line_level);
				report_field("accepted", want.accepted, out_ch.data.accepted);
				report_field("busy_res", want.busy_res, out_ch.data.busy_res);
				report_field("frame_done", want.frame_done, out_ch.data.frame_done);
			end
		end
	end

	// one transfer; valid stays high afterwards so a following item goes out back to back
	task automatic send_item(input in_item_t it);
		out_item_t r;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		predict_line(it, r);
		line_states.push_back(r);
	endtask

	task automatic send_tick();
		in_item_t it;
		it.op    = OP_TICK;
		it.red   = 8'($urandom_range(255));
		it.green = 8'($urandom_range(255));
		it.blue  = 8'($urandom_range(255));
		send_item(it);
	endtask

	task automatic send_colour(input logic [7:0] red, green, blue);
		in_item_t it;
		it.op    = OP_SEND;
		it.red   = red;
		it.green = green;
		it.blue  = blue;
		send_item(it);
	endtask

	task automatic finish_frame();
		while (tx_busy) send_tick();
	endtask

	task automatic quiesce();
		in_ch.valid <= 1'b0;
		while (line_states.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [TIMING_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		case (idx)
			REG_HIGH_ONE:  cfg_one  = val;
			REG_HIGH_ZERO: cfg_zero = val;
			REG_LOW:       cfg_low  = val;
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [TIMING_W-1:0] one, zero, low);
		finish_frame();
		quiesce();
		write_reg(REG_HIGH_ONE, one);
		write_reg(REG_HIGH_ZERO, zero);
		write_reg(REG_LOW, low);
		wr_en <= 1'b0;
	endtask

	task automatic test_idle_ticks();
		send_tick();
		send_tick();
	endtask

	// refused send part way through a frame at reset timing
	task automatic test_reset_timing();
		send_colour(8'h00, 8'h81, 8'h01);
		repeat (3) send_tick();
		send_colour(8'hFF, 8'hFF, 8'hFF);
		finish_frame();
	endtask

	// zero in a timing register behaves as one
	task automatic test_zero_timing();
		set_timing(8'd0, 8'd0, 8'd0);
		send_colour(8'h00, 8'h00, 8'h00);
		finish_frame();
		send_colour(8'hFF, 8'h00, 8'hFF);
		repeat (46) send_tick();
		send_colour(8'h12, 8'h34, 8'h56);
		finish_frame();
	endtask

	task automatic test_extreme_timing();
		set_timing(8'd255, 8'd1, 8'd1);
		send_colour(8'h00, 8'h80, 8'h00);
		finish_frame();
	endtask

	task automatic send_random_item();
		in_item_t it;
		it.red   = 8'($urandom_range(255));
		it.green = 8'($urandom_range(255));
		it.blue  = 8'($urandom_range(255));
		if (tx_busy)
			it.op = ($urandom_range(15) == 0) ? OP_SEND : OP_TICK;
		else
			it.op = ($urandom_range(2) == 0) ? OP_TICK : OP_SEND;
		send_item(it);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		set_timing(TIMING_W'($urandom_range(3)), TIMING_W'($urandom_range(3)),
			TIMING_W'($urandom_range(3)));
		repeat (55) send_random_item();
	endtask

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		wr_en        = 1'b0;
		wr_index     = REG_HIGH_ONE;
		wr_data      = '0;
		cfg_one      = HIGH_ONE_RST;
		cfg_zero     = HIGH_ZERO_RST;
		cfg_low      = LOW_RST;
		tx_shift     = '0;
		tx_bit       = '0;
		tx_high      = 1'b0;
		tx_timer     = '0;
		tx_busy      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_reset_timing();
		test_zero_timing();
		test_extreme_timing();
		test_random_traffic(0, 0);
		test_random_traffic(67, 0);
		test_random_traffic(0, 67);
		test_random_traffic(11, 11);

		quiesce();
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
